>>> src/intsrch_pkg.sv
// ----------------------------------------------------------------------------
// intsrch_pkg: shared constants for the interpolation search core
// Field widths, bus widths, item kinds and register reset values.
// ----------------------------------------------------------------------------
package intsrch_pkg;

	// Field widths of one input transaction.
	localparam int FUNC_W        = 1;
	localparam int INDEX_W       = 7;
	localparam int ITEM_VALUE_W  = 16;

	// Stream bus widths; the tdata widths are padded to whole bytes.
	localparam int IN_TDATA_W    = 24;
	localparam int IN_TUSER_W    = 1;
	localparam int OUT_TDATA_W   = 8;

	// Configuration register width and reset value.
	localparam int ENTRIES_W     = 8;
	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 8'd128;

	// Item kinds carried in tuser.
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

endpackage

>>> src/interpolation_search_core.sv
// ----------------------------------------------------------------------------
// interpolation_search_core: table load and interpolation search
// Write transactions fill a table of ascending values; search transactions
// run an interpolation search over the entries in use and return a found flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Payload
// s_axis    in         tvalid/tready    tdata: entry_index, item_value; tuser: func
// m_axis    out        tvalid/tready    tdata: found
// cfg       in         cfg_wr_en        cfg_wr_data: entries_in_use
//
// A write transaction is accepted in S_IDLE and written to the table. A search probe
// reads t[lo] and t[hi] and checks the bounds in S_LOOP, S_RLO and S_RHI, waits in
// S_DIV for the serial divider, and reads and compares the probed entry in S_POS and
// S_CMP. A search adds acceptance, the last bounds check and the result, and probes at
// most once per entry in use. s_axis_tready is high only when idle; a result waits in
// the output register while writes go on. Reset is asynchronous; the table has none.
// ----------------------------------------------------------------------------
module interpolation_search_core #(
	parameter int TABLE_DEPTH = 128,
	parameter int VALUE_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input stream: tdata = entry_index [6:0], item_value [22:7], zero pad [23].
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [intsrch_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// Input tuser = func [0].
	input  logic [intsrch_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	// Output stream: tdata = found [0], zero pad [7:1].
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [intsrch_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// Configuration: entries_in_use.
	input  logic                                 cfg_wr_en,
	input  logic [intsrch_pkg::ENTRIES_W-1:0]    cfg_wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = AW + 1;
	localparam int NW = VALUE_BITS + AW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOP,
		S_RLO,
		S_RHI,
		S_DIV,
		S_POS,
		S_CMP,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [intsrch_pkg::ENTRIES_W-1:0] entries_q;
	logic [VALUE_BITS-1:0]             key_q;
	logic [VALUE_BITS-1:0]             tl_q;
	logic [IW-1:0]                     lo_q;
	logic [IW-1:0]                     hi_q;
	logic [AW-1:0]                     pos_q;
	logic                              result_q;
	logic                              m_valid_q;
	logic                              m_found_q;

	logic [intsrch_pkg::INDEX_W-1:0]      in_index;
	logic [intsrch_pkg::ITEM_VALUE_W-1:0] in_value;
	logic [intsrch_pkg::FUNC_W-1:0]       in_func;
	logic [VALUE_BITS-1:0]                in_value_w;
	logic                                 in_accept;

	logic                  ram_we;
	logic [AW-1:0]         ram_rd_addr;
	logic [VALUE_BITS-1:0] ram_rd_data;

	logic [IW-1:0]         hi_init;
	logic [AW-1:0]         probe;
	logic [VALUE_BITS-1:0] key_off;
	logic [IW-1:0]         span;
	logic [NW-1:0]         product;
	logic [VALUE_BITS-1:0] range_w;
	logic                  div_start;
	logic                  div_done;
	logic [AW-1:0]         quotient;

	// Unpack the input transaction.
	assign in_index   = s_axis_tdata[intsrch_pkg::INDEX_W-1:0];
	assign in_value   = s_axis_tdata[intsrch_pkg::INDEX_W +: intsrch_pkg::ITEM_VALUE_W];
	assign in_func    = s_axis_tuser[intsrch_pkg::FUNC_W-1:0];
	assign in_value_w = VALUE_BITS'(in_value);
	assign in_accept  = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);

	// Table writes; indexes beyond the table are dropped.
	assign ram_we = in_accept && (in_func == intsrch_pkg::FUNC_WRITE) &&
		(32'(in_index) < TABLE_DEPTH);

	// Upper bound of a new search, from the register clamped to 1..TABLE_DEPTH.
	always_comb begin
		if (entries_q == '0) begin
			hi_init = '0;
		end else if (32'(entries_q) > TABLE_DEPTH) begin
			hi_init = IW'(TABLE_DEPTH - 1);
		end else begin
			hi_init = IW'(entries_q - 1'b1);
		end
	end

	// Probe position and read address of the table's single read port.
	assign probe = AW'(lo_q) + quotient;

	always_comb begin
		case (state_q)
			S_LOOP:  ram_rd_addr = AW'(lo_q);
			S_RLO:   ram_rd_addr = AW'(hi_q);
			S_POS:   ram_rd_addr = probe;
			default: ram_rd_addr = AW'(lo_q);
		endcase
	end

	// Numerator and denominator of the probe; bounds data arrives in S_RHI.
	assign key_off   = key_q - tl_q;
	assign span      = hi_q - lo_q;
	assign product   = NW'(key_off) * NW'(span[AW-1:0]);
	assign range_w   = ram_rd_data - tl_q;
	assign div_start = (state_q == S_RHI) && !(key_q < tl_q) && !(key_q > ram_rd_data) &&
		(ram_rd_data != tl_q);

	intsrch_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (AW'(in_index)),
		.wr_data (in_value_w),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	intsrch_div #(
		.DW (VALUE_BITS),
		.QW (AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (range_w),
		.done     (div_done),
		.quotient (quotient)
	);

	// Search sequencer, configuration register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			entries_q <= intsrch_pkg::ENTRIES_RESET;
			key_q     <= '0;
			tl_q      <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			pos_q     <= '0;
			result_q  <= 1'b0;
			m_valid_q <= 1'b0;
			m_found_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				entries_q <= cfg_wr_data;
			end
			// In S_DONE the output register is reloaded below instead.
			if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept && (in_func == intsrch_pkg::FUNC_SEARCH)) begin
						key_q   <= in_value_w;
						lo_q    <= '0;
						hi_q    <= hi_init;
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					// The read of t[lo] is issued here.
					if (lo_q > hi_q) begin
						result_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RLO;
					end
				end
				S_RLO: begin
					tl_q    <= ram_rd_data;
					state_q <= S_RHI;
				end
				S_RHI: begin
					// Key outside t[lo]..t[hi], or flat interval: answer now.
					if ((key_q < tl_q) || (key_q > ram_rd_data)) begin
						result_q <= 1'b0;
						state_q  <= S_DONE;
					end else if (ram_rd_data == tl_q) begin
						result_q <= (key_q == tl_q);
						state_q  <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					pos_q   <= probe;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Narrow the interval around the probed entry.
					if (ram_rd_data == key_q) begin
						result_q <= 1'b1;
						state_q  <= S_DONE;
					end else if (ram_rd_data < key_q) begin
						lo_q    <= IW'(pos_q) + 1'b1;
						state_q <= S_LOOP;
					end else if (pos_q == '0) begin
						result_q <= 1'b0;
						state_q  <= S_DONE;
					end else begin
						hi_q    <= IW'(pos_q) - 1'b1;
						state_q <= S_LOOP;
					end
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_found_q <= result_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(intsrch_pkg::OUT_TDATA_W-1){1'b0}}, m_found_q};

endmodule

>>> src/intsrch_ram.sv
// ----------------------------------------------------------------------------
// intsrch_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module intsrch_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/intsrch_div.sv
// ----------------------------------------------------------------------------
// intsrch_div: restoring divider with a short quotient
// Produces QW quotient bits, one per cycle. The caller guarantees that the
// quotient fits in QW bits, so the upper dividend part is below the divisor.
// ----------------------------------------------------------------------------
module intsrch_div #(
	parameter int DW = 16,
	parameter int QW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DW+QW-1:0] dividend,
	input  logic [DW-1:0]    divisor,
	output logic             done,
	output logic [QW-1:0]    quotient
);

	localparam int CNW = $clog2(QW + 1);

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  div_q;
	logic [QW-1:0]  sh_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [DW:0]    trial;
	logic           ge;
	logic [DW-1:0]  rem_d;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q, sh_q[QW-1]};
		ge    = (trial >= {1'b0, div_q});
		rem_d = ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
	end

	// Step counter and shift registers; the low dividend bits turn into quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			div_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= dividend[DW+QW-1:QW];
				sh_q   <= dividend[QW-1:0];
				div_q  <= divisor;
				cnt_q  <= CNW'(QW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_d;
				sh_q  <= QW'({sh_q, ge});
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule
